// File: hw/rtl/plbr_pkg.sv
// Shared types and constants for the polyline Bresenham rasterizer.
package plbr_pkg;

    localparam int COORD_W           = 12;
    localparam int ERR_W             = 13;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam int IMAGE_DIM_DEFAULT = 1024;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_SEGMENT = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
    } item_t;

endpackage

// File: hw/rtl/plbr_front.sv
// Front end: accepts input transfers and classifies them into engine commands.
module plbr_front
    import plbr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic signed [COORD_W-1:0] s_vx,
    input  logic signed [COORD_W-1:0] s_vy,
    input  logic                      s_restart,
    output logic                      push,
    output item_t                     push_item,
    input  logic                      q_ready
);

    logic have_prev_reg;
    logic have_prev_next;

    assign s_ready = q_ready;
    assign push    = s_valid && q_ready;

    always_comb begin
        push_item.x = s_vx;
        push_item.y = s_vy;
        if (s_op) begin
            push_item.cmd = CMD_TICK;
        end else if (s_restart || !have_prev_reg) begin
            push_item.cmd = CMD_START;
        end else begin
            push_item.cmd = CMD_SEGMENT;
        end
        have_prev_next = have_prev_reg || (push && !s_op);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else begin
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

// File: hw/rtl/plbr_queue.sv
// Small command queue between the front end and the drawing engine.
module plbr_queue
    import plbr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  push_ready,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_ready || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// File: hw/rtl/plbr_back.sv
// Drawing engine: Bresenham segment state, error update and output register.
module plbr_back
    import plbr_pkg::*;
#(
    parameter int IMAGE_DIM = IMAGE_DIM_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  item_t                     q_item,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_px,
    output logic signed [COORD_W-1:0] m_py,
    output logic                      m_in_image,
    output logic                      m_segment_end
);

    localparam logic [COORD_W-1:0] DIM = COORD_W'(IMAGE_DIM);

    logic [COORD_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [COORD_W-1:0] end_x_reg, end_x_next, end_y_reg, end_y_next;
    logic [COORD_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic               sxn_reg, sxn_next, syn_reg, syn_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic               active_reg, active_next;

    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_px_reg, out_py_reg;
    logic               out_in_reg, out_end_reg;

    logic [COORD_W:0]   diff_x, diff_y, abs_x, abs_y;
    logic [ERR_W-1:0]   err_init;
    logic [ERR_W:0]     err_wide, sum_x, dif_y, err_upd;
    logic               go_x, go_y, last, in_img, emit;

    assign pop = q_valid && (!out_valid_reg || m_ready);

    always_comb begin
        diff_x   = {q_item.x[COORD_W-1], q_item.x} - {end_x_reg[COORD_W-1], end_x_reg};
        diff_y   = {q_item.y[COORD_W-1], q_item.y} - {end_y_reg[COORD_W-1], end_y_reg};
        abs_x    = diff_x[COORD_W] ? -diff_x : diff_x;
        abs_y    = diff_y[COORD_W] ? -diff_y : diff_y;
        if (abs_x[COORD_W-1:0] > abs_y[COORD_W-1:0]) begin
            err_init = {2'b00, abs_x[COORD_W-1:1]};
        end else begin
            err_init = -{2'b00, abs_y[COORD_W-1:1]};
        end

        err_wide = {err_reg[ERR_W-1], err_reg};
        sum_x    = err_wide + {2'b00, dx_reg};
        dif_y    = err_wide - {2'b00, dy_reg};
        go_x     = !sum_x[ERR_W] && (sum_x != '0);
        go_y     = dif_y[ERR_W];
        err_upd  = err_wide - (go_x ? {2'b00, dy_reg} : '0)
                            + (go_y ? {2'b00, dx_reg} : '0);

        last   = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
        in_img = !cur_x_reg[COORD_W-1] && (cur_x_reg < DIM) &&
                 !cur_y_reg[COORD_W-1] && (cur_y_reg < DIM);
        emit   = pop && (q_item.cmd == CMD_TICK) && active_reg;

        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        end_x_next  = end_x_reg;
        end_y_next  = end_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sxn_next    = sxn_reg;
        syn_next    = syn_reg;
        err_next    = err_reg;
        active_next = active_reg;

        if (pop) begin
            case (q_item.cmd)
                CMD_START: begin
                    cur_x_next  = q_item.x;
                    cur_y_next  = q_item.y;
                    end_x_next  = q_item.x;
                    end_y_next  = q_item.y;
                    active_next = 1'b0;
                end
                CMD_SEGMENT: begin
                    cur_x_next  = end_x_reg;
                    cur_y_next  = end_y_reg;
                    end_x_next  = q_item.x;
                    end_y_next  = q_item.y;
                    dx_next     = abs_x[COORD_W-1:0];
                    dy_next     = abs_y[COORD_W-1:0];
                    sxn_next    = diff_x[COORD_W] || (diff_x == '0);
                    syn_next    = diff_y[COORD_W] || (diff_y == '0);
                    err_next    = err_init;
                    active_next = 1'b1;
                end
                CMD_TICK: begin
                    if (active_reg) begin
                        if (last) begin
                            active_next = 1'b0;
                        end else begin
                            err_next = err_upd[ERR_W-1:0];
                            if (go_x) begin
                                cur_x_next = sxn_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                            end
                            if (go_y) begin
                                cur_y_next = syn_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            sxn_reg       <= 1'b0;
            syn_reg       <= 1'b0;
            err_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            sxn_reg       <= sxn_next;
            syn_reg       <= syn_next;
            err_reg       <= err_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_px_reg  <= cur_x_reg;
            out_py_reg  <= cur_y_reg;
            out_in_reg  <= in_img;
            out_end_reg <= last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_px          = out_px_reg;
    assign m_py          = out_py_reg;
    assign m_in_image    = out_in_reg;
    assign m_segment_end = out_end_reg;

    a_segment_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_item.cmd == CMD_SEGMENT) |=> active_reg)
        else $error("segment command did not start a segment");

    a_end_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last) |=> (!active_reg && m_valid && m_segment_end))
        else $error("segment end pixel did not close the segment");

    a_no_pop_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !pop)
        else $error("engine advanced while output stalled");

endmodule

// File: hw/rtl/polyline_bresenham_rasterizer.sv
// Top level of the polyline Bresenham rasterizer: front end, queue and drawing engine.
//
// Takes one input transfer per cycle while the queue has room and, for a tick on an active
// segment, delivers one pixel transfer per cycle while m_ready is high; a vertex or an idle
// tick is consumed with no output. An accepted tick is held in the queue and then in the
// output register before its pixel appears. The rate is set by the engine's error update;
// a four-entry command queue lets the input keep accepting for up to four items while the
// pixel output is stalled. in_image marks pixels with 0 <= x, y < IMAGE_DIM.
module polyline_bresenham_rasterizer
    import plbr_pkg::*;
#(
    parameter int IMAGE_DIM = IMAGE_DIM_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic signed [COORD_W-1:0] s_vx,
    input  logic signed [COORD_W-1:0] s_vy,
    input  logic                      s_restart,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_px,
    output logic signed [COORD_W-1:0] m_py,
    output logic                      m_in_image,
    output logic                      m_segment_end
);

    logic  push, push_ready, pop, pop_valid;
    item_t push_item, pop_item;

    plbr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_vx      (s_vx),
        .s_vy      (s_vy),
        .s_restart (s_restart),
        .push      (push),
        .push_item (push_item),
        .q_ready   (push_ready)
    );

    plbr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    plbr_back #(
        .IMAGE_DIM (IMAGE_DIM)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (pop_valid),
        .q_item        (pop_item),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_px          (m_px),
        .m_py          (m_py),
        .m_in_image    (m_in_image),
        .m_segment_end (m_segment_end)
    );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for polyline_bresenham_rasterizer: directed table, then random polylines.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import plbr_pkg::*;

    localparam int   IMAGE_DIM = IMAGE_DIM_DEFAULT;
    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      in_image;
        logic                      segment_end;
    } pixel_t;

    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic                      restart;
        logic                      typed;
        logic                      typed_has;
        pixel_t                    typed_pix;
    } stim_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_op = 1'b0;
    logic signed [COORD_W-1:0] s_vx = '0;
    logic signed [COORD_W-1:0] s_vy = '0;
    logic                      s_restart = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [COORD_W-1:0] m_px;
    logic signed [COORD_W-1:0] m_py;
    logic                      m_in_image;
    logic                      m_segment_end;

    // line tracer state
    logic signed [COORD_W-1:0] pen_x = '0, pen_y = '0, tgt_x = '0, tgt_y = '0;
    int                        span_x = 0, span_y = 0, err_acc = 0;
    bit                        step_xn = 0, step_yn = 0, drawing = 0, anchored = 0;

    pixel_t    pending_pixels[$];
    stim_row_t directed_rows[$];
    pixel_t    want;
    int        mismatches = 0;
    int        counted_items = 0;
    int        stall_left = 0;
    bit        quiet = 0;

    polyline_bresenham_rasterizer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_vx          (s_vx),
        .s_vy          (s_vy),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_px          (m_px),
        .m_py          (m_py),
        .m_in_image    (m_in_image),
        .m_segment_end (m_segment_end)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit trace_pixel(input logic op, input logic signed [COORD_W-1:0] vx,
                                       input logic signed [COORD_W-1:0] vy, input logic rs,
                                       output pixel_t pix);
        int e2;
        pix = '0;
        if (op == OP_VERTEX) begin
            if (rs || !anchored) begin
                pen_x = vx;
                pen_y = vy;
                tgt_x = vx;
                tgt_y = vy;
                drawing = 0;
                anchored = 1;
                return 0;
            end
            pen_x = tgt_x;
            pen_y = tgt_y;
            tgt_x = vx;
            tgt_y = vy;
            span_x = (tgt_x > pen_x) ? int'(tgt_x) - int'(pen_x) : int'(pen_x) - int'(tgt_x);
            span_y = (tgt_y > pen_y) ? int'(tgt_y) - int'(pen_y) : int'(pen_y) - int'(tgt_y);
            step_xn = !(pen_x < tgt_x);
            step_yn = !(pen_y < tgt_y);
            err_acc = (span_x > span_y ? span_x : -span_y) / 2;
            drawing = 1;
            return 0;
        end
        if (!drawing)
            return 0;
        pix.px = pen_x;
        pix.py = pen_y;
        pix.in_image = pen_x >= 0 && pen_x < IMAGE_DIM && pen_y >= 0 && pen_y < IMAGE_DIM;
        pix.segment_end = (pen_x == tgt_x) && (pen_y == tgt_y);
        if (pix.segment_end) begin
            drawing = 0;
        end else begin
            e2 = err_acc;
            if (e2 > -span_x) begin
                err_acc -= span_y;
                pen_x = COORD_W'(int'(pen_x) + (step_xn ? -1 : 1));
            end
            if (e2 < span_y) begin
                err_acc += span_x;
                pen_y = COORD_W'(int'(pen_y) + (step_yn ? -1 : 1));
            end
        end
        return 1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return $urandom_range(0, 12) - 4;
        if (r < 50)
            return 1016 + $urandom_range(0, 12);
        if (r < 70)
            return $urandom_range(0, 4095) - 2048;
        return $urandom_range(0, 1150) - 50;
    endfunction

    function automatic void add_row(logic op, int vx, int vy, logic rs, bit typed = 0,
                                    bit typed_has = 0, int px = 0, int py = 0,
                                    bit img = 0, bit seg_end = 0);
        stim_row_t r;
        r.op = op;
        r.vx = COORD_W'(vx);
        r.vy = COORD_W'(vy);
        r.restart = rs;
        r.typed = typed;
        r.typed_has = typed_has;
        r.typed_pix.px = COORD_W'(px);
        r.typed_pix.py = COORD_W'(py);
        r.typed_pix.in_image = img;
        r.typed_pix.segment_end = seg_end;
        directed_rows.push_back(r);
    endfunction

    task automatic apply_item(input logic op, input logic signed [COORD_W-1:0] vx,
                              input logic signed [COORD_W-1:0] vy, input logic rs,
                              input bit typed, input bit typed_has, input pixel_t typed_pix);
        int     gap;
        bit     has;
        pixel_t pix;
        @(negedge aclk);
        gap = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_vx      <= vx;
        s_vy      <= vy;
        s_restart <= rs;
        do @(posedge aclk); while (!s_ready);
        has = trace_pixel(op, vx, vy, rs, pix);
        if (typed) begin
            if (typed_has)
                pending_pixels.push_back(typed_pix);
        end else if (has) begin
            pending_pixels.push_back(pix);
        end
        if (op == OP_VERTEX || has)
            counted_items++;
    endtask

    task automatic tick_burst(input int n);
        repeat (n) apply_item(OP_TICK, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom),
                              0, 0, '0);
    endtask

    // result side: random stalls, none started while quiet
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: pixel transfer with none expected: px %0d py %0d img %0b end %0b",
                         $time, m_px, m_py, m_in_image, m_segment_end);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_px !== want.px) begin
                    $display("%0t: px expected %0d actual %0d", $time, want.px, m_px);
                    mismatches++;
                end
                if (m_py !== want.py) begin
                    $display("%0t: py expected %0d actual %0d", $time, want.py, m_py);
                    mismatches++;
                end
                if (m_in_image !== want.in_image) begin
                    $display("%0t: in_image expected %0b actual %0b", $time, want.in_image,
                             m_in_image);
                    mismatches++;
                end
                if (m_segment_end !== want.segment_end) begin
                    $display("%0t: segment_end expected %0b actual %0b", $time,
                             want.segment_end, m_segment_end);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        stim_row_t                 r;
        int                        kind;
        int                        n;
        int                        nx;
        int                        ny;
        logic                      rs;

        add_row(OP_TICK, 5, -7, 1, 1, 0);
        add_row(OP_VERTEX, 0, 0, 0, 1, 0);
        add_row(OP_VERTEX, 0, 0, 0);
        add_row(OP_TICK, 0, 0, 0, 1, 1, 0, 0, 1, 1);
        add_row(OP_TICK, 0, 0, 0, 1, 0);
        add_row(OP_VERTEX, 3, 1, 0);
        repeat (4) add_row(OP_TICK, -1, 2047, 1);
        add_row(OP_VERTEX, -2048, -2048, 1);
        add_row(OP_VERTEX, 2047, 2047, 0);
        add_row(OP_TICK, 0, 0, 0, 1, 1, -2048, -2048, 0, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_VERTEX, 1023, 1024, 0);
        add_row(OP_TICK, 0, 0, 0, 1, 1, 2047, 2047, 0, 0);
        add_row(OP_VERTEX, 1023, 0, 1);
        add_row(OP_VERTEX, 1024, -1, 0);
        repeat (2) add_row(OP_TICK, 0, 0, 0);
        add_row(OP_VERTEX, -1, 1023, 1);
        add_row(OP_VERTEX, 0, 1020, 0);
        repeat (4) add_row(OP_TICK, 0, 0, 0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            apply_item(r.op, r.vx, r.vy, r.restart, r.typed, r.typed_has, r.typed_pix);
        end

        counted_items = 0;
        while (counted_items < 1150) begin
            quiet = ($urandom_range(0, 9) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                tick_burst($urandom_range(1, 4));
            end else if (kind < 15) begin
                apply_item(OP_VERTEX, COORD_W'(pick_coord()), COORD_W'(pick_coord()), 1'b1,
                           0, 0, '0);
            end else begin
                if ($urandom_range(0, 99) < 80) begin
                    nx = int'(tgt_x) + $urandom_range(0, 24) - 12;
                    ny = int'(tgt_y) + $urandom_range(0, 24) - 12;
                end else begin
                    nx = pick_coord();
                    ny = pick_coord();
                end
                rs = ($urandom_range(0, 19) == 0);
                apply_item(OP_VERTEX, COORD_W'(nx), COORD_W'(ny), rs, 0, 0, '0);
                if (drawing) begin
                    n = (span_x > span_y ? span_x : span_y) + 1;
                    kind = $urandom_range(0, 99);
                    if (n > 400 || (n > 60 && kind < 50))
                        tick_burst($urandom_range(1, 40));
                    else if (kind < 85)
                        tick_burst(n);
                    else if (kind < 95)
                        tick_burst(n + $urandom_range(1, 3));
                    else
                        tick_burst($urandom_range(0, n - 1));
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        quiet = 0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
